// ----- hdl/pcdf_pkg.sv -----
// shared types, constants and helpers of the pair cutoff distance filter
package pcdf_pkg;

  localparam int unsigned DIMS       = 3;
  localparam int unsigned MAX_PAIRS  = 1024;
  localparam int unsigned AXES       = 3;

  localparam int unsigned IDX_W      = 10;
  localparam int unsigned DIM_W      = 2;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned LEN_W      = 31;
  localparam int unsigned CUT_W      = 63;
  localparam int unsigned SQ_W       = 64;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned MOVE_W     = POS_W + 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 63;

  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_PAIRS);
  localparam logic [DIM_W-1:0] LAST_DIM = DIM_W'(DIMS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_X  = 2'd0,
    CFG_BOX_Y  = 2'd1,
    CFG_BOX_Z  = 2'd2,
    CFG_CUTOFF = 2'd3
  } pcdf_cfg_e;

  typedef struct packed {
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] second;
    logic [DIM_W-1:0] dim;
    logic             eos;
  } pcdf_meta_t;

  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
    logic fire;
  } pcdf_ctl_t;

  function automatic logic dim_ok(logic [DIM_W-1:0] dim);
    return int'(dim) < int'(DIMS);
  endfunction

  function automatic logic [POS_W-1:0] sat32(logic [POS_W+2:0] v);
    logic [POS_W-1:0] r;
    if ($signed(v) > 35'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if ($signed(v) < -35'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/pcdf_sep.sv -----
// minimum-image separation and next-slice separation stages
module pcdf_sep (
  input  logic                        clk_i,
  input  pcdf_pkg::pcdf_ctl_t         ctl_i,
  input  pcdf_pkg::pcdf_meta_t        meta_i,
  input  logic [pcdf_pkg::POS_W-1:0]  a_now_i,
  input  logic [pcdf_pkg::POS_W-1:0]  b_now_i,
  input  logic [pcdf_pkg::POS_W-1:0]  a_next_i,
  input  logic [pcdf_pkg::POS_W-1:0]  b_next_i,
  input  logic [pcdf_pkg::LEN_W-1:0]  len_i,
  output pcdf_pkg::pcdf_meta_t        meta_o,
  output logic [pcdf_pkg::POS_W-1:0]  d_o,
  output logic [pcdf_pkg::POS_W-1:0]  dn_o
);

  logic [pcdf_pkg::POS_W:0]    diff;
  logic [pcdf_pkg::MOVE_W-1:0] diff_x;
  logic [pcdf_pkg::MOVE_W-1:0] twod;
  logic [pcdf_pkg::MOVE_W-1:0] len_s;
  logic [pcdf_pkg::MOVE_W-1:0] wrapped;
  logic [pcdf_pkg::POS_W:0]    move_a;
  logic [pcdf_pkg::POS_W:0]    move_b;
  logic [pcdf_pkg::MOVE_W-1:0] move;
  logic [pcdf_pkg::POS_W+2:0]  next_sum;

  pcdf_pkg::pcdf_meta_t        meta1_q;
  logic [pcdf_pkg::POS_W-1:0]  d1_q;
  logic [pcdf_pkg::MOVE_W-1:0] move1_q;
  pcdf_pkg::pcdf_meta_t        meta2_q;
  logic [pcdf_pkg::POS_W-1:0]  d2_q;
  logic [pcdf_pkg::POS_W-1:0]  dn2_q;

  always_comb begin
    diff    = {a_now_i[pcdf_pkg::POS_W-1], a_now_i} - {b_now_i[pcdf_pkg::POS_W-1], b_now_i};
    diff_x  = {diff[pcdf_pkg::POS_W], diff};
    twod    = {diff, 1'b0};
    len_s   = {3'b000, len_i};
    if ($signed(twod) >= $signed(len_s)) begin
      wrapped = diff_x - len_s;
    end else if ($signed(twod) <= -$signed(len_s)) begin
      wrapped = diff_x + len_s;
    end else begin
      wrapped = diff_x;
    end
    move_a  = {a_next_i[pcdf_pkg::POS_W-1], a_next_i} - {a_now_i[pcdf_pkg::POS_W-1], a_now_i};
    move_b  = {b_next_i[pcdf_pkg::POS_W-1], b_next_i} - {b_now_i[pcdf_pkg::POS_W-1], b_now_i};
    move    = {move_a[pcdf_pkg::POS_W], move_a} - {move_b[pcdf_pkg::POS_W], move_b};
  end

  always_comb begin
    next_sum = {{3{d1_q[pcdf_pkg::POS_W-1]}}, d1_q}
             + {move1_q[pcdf_pkg::MOVE_W-1], move1_q};
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld1) begin
      meta1_q <= meta_i;
      d1_q    <= pcdf_pkg::sat32({wrapped[pcdf_pkg::MOVE_W-1], wrapped});
      move1_q <= move;
    end
    if (ctl_i.ld2) begin
      meta2_q <= meta1_q;
      d2_q    <= d1_q;
      dn2_q   <= pcdf_pkg::sat32(next_sum);
    end
  end

  assign meta_o = meta2_q;
  assign d_o    = d2_q;
  assign dn_o   = dn2_q;

endmodule

// ----- hdl/pcdf_acc.sv -----
// squaring stage and saturating square-sum accumulators
module pcdf_acc (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pcdf_pkg::pcdf_ctl_t         ctl_i,
  input  pcdf_pkg::pcdf_meta_t        meta_i,
  input  logic [pcdf_pkg::POS_W-1:0]  d_i,
  input  logic [pcdf_pkg::POS_W-1:0]  dn_i,
  output pcdf_pkg::pcdf_meta_t        meta_o,
  output logic [pcdf_pkg::POS_W-1:0]  d_o,
  output logic [pcdf_pkg::POS_W-1:0]  dn_o,
  output logic [pcdf_pkg::SQ_W-1:0]   acc_o,
  output logic [pcdf_pkg::SQ_W-1:0]   nacc_o
);

  logic signed [pcdf_pkg::POS_W-1:0] d_s;
  logic signed [pcdf_pkg::POS_W-1:0] dn_s;
  logic signed [pcdf_pkg::SQ_W-1:0]  sq;
  logic signed [pcdf_pkg::SQ_W-1:0]  nsq;

  pcdf_pkg::pcdf_meta_t        meta3_q;
  logic [pcdf_pkg::POS_W-1:0]  d3_q;
  logic [pcdf_pkg::POS_W-1:0]  dn3_q;
  logic [pcdf_pkg::SQ_W-1:0]   sq3_q;
  logic [pcdf_pkg::SQ_W-1:0]   nsq3_q;

  pcdf_pkg::pcdf_meta_t        meta4_q;
  logic [pcdf_pkg::POS_W-1:0]  d4_q;
  logic [pcdf_pkg::POS_W-1:0]  dn4_q;
  logic [pcdf_pkg::SQ_W-1:0]   acc_q, acc_d;
  logic [pcdf_pkg::SQ_W-1:0]   nacc_q, nacc_d;

  logic [pcdf_pkg::SQ_W-1:0]   base;
  logic [pcdf_pkg::SQ_W-1:0]   nbase;
  logic [pcdf_pkg::SQ_W:0]     sum;
  logic [pcdf_pkg::SQ_W:0]     nsum;
  logic                        start;

  always_comb begin
    d_s  = $signed(d_i);
    dn_s = $signed(dn_i);
    sq   = d_s * d_s;
    nsq  = dn_s * dn_s;
  end

  // pair start drops the previous sums
  always_comb begin
    start = (meta3_q.dim == '0);
    base  = start ? '0 : acc_q;
    nbase = start ? '0 : nacc_q;
    sum   = {1'b0, base} + {1'b0, sq3_q};
    nsum  = {1'b0, nbase} + {1'b0, nsq3_q};
    acc_d  = acc_q;
    nacc_d = nacc_q;
    if (pcdf_pkg::dim_ok(meta3_q.dim)) begin
      acc_d  = sum[pcdf_pkg::SQ_W] ? '1 : sum[pcdf_pkg::SQ_W-1:0];
      nacc_d = nsum[pcdf_pkg::SQ_W] ? '1 : nsum[pcdf_pkg::SQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld3) begin
      meta3_q <= meta_i;
      d3_q    <= d_i;
      dn3_q   <= dn_i;
      sq3_q   <= sq;
      nsq3_q  <= nsq;
    end
    if (ctl_i.ld4) begin
      meta4_q <= meta3_q;
      d4_q    <= d3_q;
      dn4_q   <= dn3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      nacc_q <= '0;
    end else if (ctl_i.ld4) begin
      acc_q  <= acc_d;
      nacc_q <= nacc_d;
    end
  end

  assign meta_o = meta4_q;
  assign d_o    = d4_q;
  assign dn_o   = dn4_q;
  assign acc_o  = acc_q;
  assign nacc_o = nacc_q;

endmodule

// ----- hdl/pcdf_sel.sv -----
// cutoff decision, kept-pair numbering, separation stores and result register
module pcdf_sel (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pcdf_pkg::pcdf_ctl_t         ctl_i,
  input  pcdf_pkg::pcdf_meta_t        meta_i,
  input  logic [pcdf_pkg::POS_W-1:0]  d_i,
  input  logic [pcdf_pkg::POS_W-1:0]  dn_i,
  input  logic [pcdf_pkg::SQ_W-1:0]   acc_i,
  input  logic [pcdf_pkg::SQ_W-1:0]   nacc_i,
  input  logic [pcdf_pkg::CUT_W-1:0]  cut_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        kept_o,
  output logic [pcdf_pkg::SLOT_W-1:0] slot_o,
  output logic [pcdf_pkg::IDX_W-1:0]  pair_first_o,
  output logic [pcdf_pkg::IDX_W-1:0]  pair_second_o,
  output logic [pcdf_pkg::POS_W-1:0]  sep_x_o,
  output logic [pcdf_pkg::POS_W-1:0]  sep_y_o,
  output logic [pcdf_pkg::POS_W-1:0]  sep_z_o,
  output logic [pcdf_pkg::POS_W-1:0]  next_sep_x_o,
  output logic [pcdf_pkg::POS_W-1:0]  next_sep_y_o,
  output logic [pcdf_pkg::POS_W-1:0]  next_sep_z_o,
  output logic                        slice_done_o,
  output logic [pcdf_pkg::CNT_W-1:0]  slice_count_o
);

  logic [pcdf_pkg::POS_W-1:0]  sep_store_q [pcdf_pkg::AXES];
  logic [pcdf_pkg::POS_W-1:0]  nsep_store_q [pcdf_pkg::AXES];
  logic [pcdf_pkg::POS_W-1:0]  sep_q [pcdf_pkg::AXES];
  logic [pcdf_pkg::POS_W-1:0]  nsep_q [pcdf_pkg::AXES];

  logic [pcdf_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [pcdf_pkg::CNT_W-1:0]  cnt_after;
  logic                        out_v_q, out_v_d;
  logic                        kept_q;
  logic [pcdf_pkg::SLOT_W-1:0] slot_q;
  logic [pcdf_pkg::IDX_W-1:0]  first_q;
  logic [pcdf_pkg::IDX_W-1:0]  second_q;
  logic                        done_q;
  logic [pcdf_pkg::CNT_W-1:0]  scnt_q;

  logic                        ok;
  logic                        keep;
  logic                        has_res;
  logic                        load;

  always_comb begin
    ok        = pcdf_pkg::dim_ok(meta_i.dim);
    keep      = ok && (meta_i.dim == pcdf_pkg::LAST_DIM)
              && (acc_i < {1'b0, cut_i}) && (nacc_i < {1'b0, cut_i})
              && (cnt_q < pcdf_pkg::MAX_CNT);
    has_res   = keep || meta_i.eos;
    load      = ctl_i.fire && has_res;
    cnt_after = cnt_q + pcdf_pkg::CNT_W'(keep);
    cnt_d     = cnt_q;
    if (ctl_i.fire) begin
      cnt_d = meta_i.eos ? '0 : cnt_after;
    end
    out_v_d   = load || (out_v_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < pcdf_pkg::AXES; k++) begin
      if (ctl_i.fire && ok && (meta_i.dim == pcdf_pkg::DIM_W'(k))) begin
        sep_store_q[k]  <= d_i;
        nsep_store_q[k] <= dn_i;
      end
    end
  end

  // the closing axis comes straight from the pipe, the others from the stores
  always_ff @(posedge clk_i) begin
    if (load) begin
      kept_q   <= keep;
      slot_q   <= keep ? cnt_q[pcdf_pkg::SLOT_W-1:0] : '0;
      first_q  <= keep ? meta_i.first : '0;
      second_q <= keep ? meta_i.second : '0;
      done_q   <= meta_i.eos;
      scnt_q   <= cnt_after;
      for (int k = 0; k < pcdf_pkg::AXES; k++) begin
        if (!keep || k >= pcdf_pkg::DIMS) begin
          sep_q[k]  <= '0;
          nsep_q[k] <= '0;
        end else if (meta_i.dim == pcdf_pkg::DIM_W'(k)) begin
          sep_q[k]  <= d_i;
          nsep_q[k] <= dn_i;
        end else begin
          sep_q[k]  <= sep_store_q[k];
          nsep_q[k] <= nsep_store_q[k];
        end
      end
    end
  end

  assign out_valid_o   = out_v_q;
  assign kept_o        = kept_q;
  assign slot_o        = slot_q;
  assign pair_first_o  = first_q;
  assign pair_second_o = second_q;
  assign sep_x_o       = sep_q[0];
  assign sep_y_o       = sep_q[1];
  assign sep_z_o       = sep_q[2];
  assign next_sep_x_o  = nsep_q[0];
  assign next_sep_y_o  = nsep_q[1];
  assign next_sep_z_o  = nsep_q[2];
  assign slice_done_o  = done_q;
  assign slice_count_o = scnt_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= pcdf_pkg::MAX_CNT)
    else $error("kept count beyond list size");

  a_slot_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && kept_q) |-> ({1'b0, slot_q} + 11'd1 == scnt_q))
    else $error("slot and slice count disagree");

  a_drop_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !kept_q) |-> done_q)
    else $error("result without kept pair or slice end");

  a_slice_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.fire && meta_i.eos) |=> (cnt_q == '0))
    else $error("count not cleared at slice end");

endmodule

// ----- hdl/pair_cutoff_distance_filter_core.sv -----
// top level of the pair cutoff distance filter: input register, stage control, config
//
//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+-----------------------------
//  in       | in        | in_valid_i / in_ready_o        | one axis of one candidate pair
//  out      | out       | out_valid_o / out_ready_i      | kept pair and/or slice count
//  cfg      | in        | cfg_valid_i / cfg_ready_o      | cfg_index_i, cfg_data_i
//
//  one request per cycle sustained while the output is not stalled
//  stages: input reg, wrap, next-slice add, squarers, accumulators, result register
//  the 32x32 squarers and the 64-bit saturating accumulate set the stage boundaries
//  a stalled output holds the result register; upstream stages keep filling empty slots
//  reset clears stage valid bits, sums, kept count and config registers; cfg_ready_o is
//  always high
module pair_cutoff_distance_filter_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [pcdf_pkg::IDX_W-1:0]       first_index_i,
  input  logic [pcdf_pkg::IDX_W-1:0]       second_index_i,
  input  logic [pcdf_pkg::DIM_W-1:0]       dimension_i,
  input  logic signed [pcdf_pkg::POS_W-1:0] first_pos_now_i,
  input  logic signed [pcdf_pkg::POS_W-1:0] second_pos_now_i,
  input  logic signed [pcdf_pkg::POS_W-1:0] first_pos_next_i,
  input  logic signed [pcdf_pkg::POS_W-1:0] second_pos_next_i,
  input  logic                             end_of_slice_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             kept_o,
  output logic [pcdf_pkg::SLOT_W-1:0]      slot_o,
  output logic [pcdf_pkg::IDX_W-1:0]       pair_first_o,
  output logic [pcdf_pkg::IDX_W-1:0]       pair_second_o,
  output logic signed [pcdf_pkg::POS_W-1:0] sep_x_o,
  output logic signed [pcdf_pkg::POS_W-1:0] sep_y_o,
  output logic signed [pcdf_pkg::POS_W-1:0] sep_z_o,
  output logic signed [pcdf_pkg::POS_W-1:0] next_sep_x_o,
  output logic signed [pcdf_pkg::POS_W-1:0] next_sep_y_o,
  output logic signed [pcdf_pkg::POS_W-1:0] next_sep_z_o,
  output logic                             slice_done_o,
  output logic [pcdf_pkg::CNT_W-1:0]       slice_count_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pcdf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pcdf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic [pcdf_pkg::LEN_W-1:0] box_x_q;
  logic [pcdf_pkg::LEN_W-1:0] box_y_q;
  logic [pcdf_pkg::LEN_W-1:0] box_z_q;
  logic [pcdf_pkg::CUT_W-1:0] cut_q;
  logic [pcdf_pkg::LEN_W-1:0] len;

  pcdf_pkg::pcdf_meta_t       meta0_q;
  logic [pcdf_pkg::POS_W-1:0] a_now_q;
  logic [pcdf_pkg::POS_W-1:0] b_now_q;
  logic [pcdf_pkg::POS_W-1:0] a_next_q;
  logic [pcdf_pkg::POS_W-1:0] b_next_q;

  logic [4:0] v_q, v_d;
  logic [4:0] mv;
  logic [4:0] free;
  logic       out_free;
  logic       in_fire;
  pcdf_pkg::pcdf_ctl_t ctl;

  pcdf_pkg::pcdf_meta_t       meta2, meta4;
  logic [pcdf_pkg::POS_W-1:0] d2, dn2, d4, dn4;
  logic [pcdf_pkg::SQ_W-1:0]  acc4, nacc4;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q <= '0;
      box_y_q <= '0;
      box_z_q <= '0;
      cut_q   <= '0;
    end else if (cfg_valid_i) begin
      case (pcdf_pkg::pcdf_cfg_e'(cfg_index_i))
        pcdf_pkg::CFG_BOX_X:  box_x_q <= cfg_data_i[pcdf_pkg::LEN_W-1:0];
        pcdf_pkg::CFG_BOX_Y:  box_y_q <= cfg_data_i[pcdf_pkg::LEN_W-1:0];
        pcdf_pkg::CFG_BOX_Z:  box_z_q <= cfg_data_i[pcdf_pkg::LEN_W-1:0];
        pcdf_pkg::CFG_CUTOFF: cut_q   <= cfg_data_i[pcdf_pkg::CUT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage k moves on when the slot after it is empty or moving
  always_comb begin
    out_free = !out_valid_o || out_ready_i;
    mv[4]    = v_q[4] && out_free;
    free[4]  = !v_q[4] || mv[4];
    for (int k = 3; k >= 0; k--) begin
      mv[k]   = v_q[k] && free[k+1];
      free[k] = !v_q[k] || mv[k];
    end
    in_ready_o = free[0];
    in_fire    = in_valid_i && free[0];
    v_d[0]     = in_fire || (v_q[0] && !mv[0]);
    for (int k = 1; k < 5; k++) begin
      v_d[k] = mv[k-1] || (v_q[k] && !mv[k]);
    end
    ctl.ld1  = mv[0];
    ctl.ld2  = mv[1];
    ctl.ld3  = mv[2];
    ctl.ld4  = mv[3];
    ctl.fire = mv[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      meta0_q.first  <= first_index_i;
      meta0_q.second <= second_index_i;
      meta0_q.dim    <= dimension_i;
      meta0_q.eos    <= end_of_slice_i;
      a_now_q        <= first_pos_now_i;
      b_now_q        <= second_pos_now_i;
      a_next_q       <= first_pos_next_i;
      b_next_q       <= second_pos_next_i;
    end
  end

  always_comb begin
    case (meta0_q.dim)
      2'd1:    len = box_y_q;
      2'd2:    len = box_z_q;
      default: len = box_x_q;
    endcase
  end

  pcdf_sep u_sep (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .meta_i   (meta0_q),
    .a_now_i  (a_now_q),
    .b_now_i  (b_now_q),
    .a_next_i (a_next_q),
    .b_next_i (b_next_q),
    .len_i    (len),
    .meta_o   (meta2),
    .d_o      (d2),
    .dn_o     (dn2)
  );

  pcdf_acc u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .meta_i (meta2),
    .d_i    (d2),
    .dn_i   (dn2),
    .meta_o (meta4),
    .d_o    (d4),
    .dn_o   (dn4),
    .acc_o  (acc4),
    .nacc_o (nacc4)
  );

  pcdf_sel u_sel (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .meta_i        (meta4),
    .d_i           (d4),
    .dn_i          (dn4),
    .acc_i         (acc4),
    .nacc_i        (nacc4),
    .cut_i         (cut_q),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .kept_o        (kept_o),
    .slot_o        (slot_o),
    .pair_first_o  (pair_first_o),
    .pair_second_o (pair_second_o),
    .sep_x_o       (sep_x_o),
    .sep_y_o       (sep_y_o),
    .sep_z_o       (sep_z_o),
    .next_sep_x_o  (next_sep_x_o),
    .next_sep_y_o  (next_sep_y_o),
    .next_sep_z_o  (next_sep_z_o),
    .slice_done_o  (slice_done_o),
    .slice_count_o (slice_count_o)
  );

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[4] && out_valid_o && !out_ready_i) |=> v_q[4])
    else $error("last stage lost a request under stall");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q == 5'b11111 && out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("request taken with a full pipe");

endmodule
